// ===== hdl/dedup_history_ring_assert.svh =====
// assertion macros for the deduplicating handle ring
// expects clk and arst_n in the scope of each use
`ifndef DEDUP_HISTORY_RING_ASSERT_SVH
`define DEDUP_HISTORY_RING_ASSERT_SVH

// same-cycle implication, off while reset is low
`define DHR_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("dhr assertion failed");

// next-cycle implication, off while reset is low
`define DHR_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("dhr assertion failed");

`endif

// ===== hdl/dhr_pkg.sv =====
// shared types and constants of the deduplicating handle ring
// no dependencies
package dhr_pkg;

	localparam int HANDLE_W = 32;
	localparam int POS_W    = 9;
	localparam int LIVE_W   = 9;
	localparam int STATUS_W = 3;

	localparam logic CMD_SAVE = 1'b0;
	localparam logic CMD_READ = 1'b1;

	typedef enum logic [STATUS_W-1:0] {
		STAT_STORED  = 3'd0,
		STAT_DUP     = 3'd1,
		STAT_ZERO    = 3'd2,
		STAT_READ_OK = 3'd3,
		STAT_BEYOND  = 3'd4
	} dhr_status_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DECODE,
		ST_FETCH,
		ST_SCAN,
		ST_RESULT
	} dhr_state_t;

	// controller to datapath
	typedef struct packed {
		logic        capture;
		logic        fetch;
		logic        scan_init;
		logic        scan_run;
		logic        store;
		logic        res_set;
		dhr_status_t res_code;
		logic        res_take_data;
		logic        out_load;
	} dhr_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic is_read;
		logic pos_ok;
		logic zero_handle;
		logic scan_more;
		logic cmp_valid;
		logic cmp_hit;
		logic out_free;
	} dhr_sts_t;

endpackage

// ===== hdl/dedup_history_ring.sv =====
// top level of the deduplicating handle ring
// depends on dhr_pkg, dhr_ctrl, dhr_dp (and through it dhr_ram)

// A ring of up to ENTRIES-1 recent unique nonzero 32-bit handles. A save beat
// (cmd 0) offers a handle: zero is ignored (status 2), a handle equal to any
// live entry is reported as a duplicate (status 1), anything else is appended
// after the newest entry (status 0) and, when the ring is full, the oldest
// entry is dropped and evicted is set. A read beat (cmd 1) returns the live
// entry at the given age position counted from the oldest (status 3), or
// status 4 with handle_out zero when the position is not below the live
// count. Every beat in gives exactly one beat out, with live_count as it
// stands after that beat. The block works on one beat at a time. A save
// that is not zero runs the duplicate scan, which reads one live entry per
// cycle through the single read port of the handle ram, oldest first, and
// stops at the first match, so a save takes longer the more entries are
// live before it. A finished result sits in an output register, so the next
// beat is accepted while it waits; the block stalls only when a second
// result is ready before the first was taken. The handle ram needs no
// clearing after reset: only live entries are ever read, and each was
// written first.
module dedup_history_ring
	import dhr_pkg::*;
#(
	parameter int ENTRIES = 512
) (
	input  logic                clk,
	input  logic                arst_n,
	// input channel
	input  logic                in_valid,
	output logic                in_ready,
	input  logic                cmd,
	input  logic [HANDLE_W-1:0] handle,
	input  logic [POS_W-1:0]    position,
	// output channel
	output logic                out_valid,
	input  logic                out_ready,
	output logic [STATUS_W-1:0] status,
	output logic [HANDLE_W-1:0] handle_out,
	output logic [LIVE_W-1:0]   live_count,
	output logic                evicted
);

	// command and status between the state machine and the datapath
	dhr_cmd_t ctrl_cmd;
	dhr_sts_t dp_sts;

	// sequences capture, decode, fetch or scan, and result hand-off
	dhr_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.sts     (dp_sts),
		.cmd     (ctrl_cmd)
	);

	// holds the ring pointers, the handle ram, the scan counters and the output beat
	dhr_dp #(
		.ENTRIES(ENTRIES)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_in    (cmd),
		.handle    (handle),
		.position  (position),
		.cmd       (ctrl_cmd),
		.sts       (dp_sts),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.status    (status),
		.handle_out(handle_out),
		.live_count(live_count),
		.evicted   (evicted)
	);

endmodule

// ===== hdl/dhr_ram.sv =====
// generic single-write, single-read ram with registered read data
// no dependencies
module dhr_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 512
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ===== hdl/dhr_ctrl.sv =====
// controller state machine of the deduplicating handle ring
// depends on dhr_pkg and dedup_history_ring_assert.svh
`include "dedup_history_ring_assert.svh"

module dhr_ctrl
	import dhr_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_ready,
	input  dhr_sts_t sts,
	output dhr_cmd_t cmd
);

	dhr_state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) state_d = ST_DECODE;
			end
			ST_DECODE: begin
				if (sts.is_read) begin
					state_d = sts.pos_ok ? ST_FETCH : ST_RESULT;
				end else begin
					state_d = sts.zero_handle ? ST_RESULT : ST_SCAN;
				end
			end
			ST_FETCH: begin
				state_d = ST_RESULT;
			end
			ST_SCAN: begin
				if (sts.cmp_hit || (!sts.scan_more && !sts.cmp_valid)) state_d = ST_RESULT;
			end
			ST_RESULT: begin
				if (sts.out_free) state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// outputs
	always_comb begin
		cmd          = '0;
		cmd.res_code = STAT_STORED;
		in_ready     = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready    = 1'b1;
				cmd.capture = in_valid;
			end
			ST_DECODE: begin
				if (sts.is_read) begin
					if (sts.pos_ok) begin
						cmd.fetch = 1'b1;
					end else begin
						cmd.res_set  = 1'b1;
						cmd.res_code = STAT_BEYOND;
					end
				end else if (sts.zero_handle) begin
					cmd.res_set  = 1'b1;
					cmd.res_code = STAT_ZERO;
				end else begin
					cmd.scan_init = 1'b1;
				end
			end
			ST_FETCH: begin
				cmd.res_set       = 1'b1;
				cmd.res_code      = STAT_READ_OK;
				cmd.res_take_data = 1'b1;
			end
			ST_SCAN: begin
				if (sts.cmp_hit) begin
					cmd.res_set  = 1'b1;
					cmd.res_code = STAT_DUP;
				end else if (!sts.scan_more && !sts.cmp_valid) begin
					cmd.store    = 1'b1;
					cmd.res_set  = 1'b1;
					cmd.res_code = STAT_STORED;
				end else begin
					cmd.scan_run = 1'b1;
				end
			end
			ST_RESULT: begin
				cmd.out_load = sts.out_free;
			end
			default: begin
				in_ready = 1'b0;
			end
		endcase
	end

	`DHR_ASSERT_NEXT(a_accept_decodes, (state_q == ST_IDLE) && in_valid, state_q == ST_DECODE)
	`DHR_ASSERT_IMP(a_load_when_free, cmd.out_load, sts.out_free)
	`DHR_ASSERT_IMP(a_store_after_scan, cmd.store, !sts.cmp_valid && !sts.scan_more)

endmodule

// ===== hdl/dhr_dp.sv =====
// datapath of the deduplicating handle ring: ring pointers, handle ram, scan, result
// depends on dhr_pkg, dhr_ram and dedup_history_ring_assert.svh
`include "dedup_history_ring_assert.svh"

module dhr_dp
	import dhr_pkg::*;
#(
	parameter int ENTRIES = 512
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cmd_in,
	input  logic [HANDLE_W-1:0] handle,
	input  logic [POS_W-1:0]    position,
	input  dhr_cmd_t            cmd,
	output dhr_sts_t            sts,
	output logic                out_valid,
	input  logic                out_ready,
	output logic [STATUS_W-1:0] status,
	output logic [HANDLE_W-1:0] handle_out,
	output logic [LIVE_W-1:0]   live_count,
	output logic                evicted
);

	localparam int AW   = $clog2(ENTRIES);
	localparam int CMPW = (AW > POS_W) ? AW : POS_W;

	// ring state
	logic [AW-1:0] oldest_q;
	logic [AW-1:0] count_q;
	logic          full;

	// captured beat
	logic                cap_cmd_q;
	logic [HANDLE_W-1:0] cap_handle_q;
	logic [POS_W-1:0]    cap_position_q;

	// scan
	logic [AW-1:0] age_q;
	logic [AW-1:0] scan_slot_q;
	logic          cmp_vld_q;
	logic          scan_issue;

	// result staging and output
	dhr_status_t         res_status_q;
	logic [HANDLE_W-1:0] res_handle_q;
	logic                res_evicted_q;
	logic                out_valid_q;
	dhr_status_t         out_status_q;
	logic [HANDLE_W-1:0] out_handle_q;
	logic [LIVE_W-1:0]   out_live_q;
	logic                out_evicted_q;

	// ram
	logic                ram_re;
	logic [AW-1:0]       ram_raddr;
	logic [HANDLE_W-1:0] ram_rdata;

	logic [CMPW-1:0] pos_ext;
	logic [CMPW-1:0] count_ext;
	logic [AW:0]     pos_sum;
	logic [AW-1:0]   pos_slot;

	function automatic logic [AW-1:0] slot_inc(input logic [AW-1:0] s);
		return (s == AW'(ENTRIES - 1)) ? '0 : s + 1'b1;
	endfunction

	assign full      = (count_q == AW'(ENTRIES - 1));
	assign pos_ext   = CMPW'(cap_position_q);
	assign count_ext = CMPW'(count_q);

	// slot of a read position, valid only when the position is below the count
	assign pos_sum  = {1'b0, oldest_q} + {1'b0, pos_ext[AW-1:0]};
	assign pos_slot = (pos_sum >= (AW+1)'(ENTRIES)) ? AW'(pos_sum - (AW+1)'(ENTRIES))
	                                                : pos_sum[AW-1:0];

	assign scan_issue = cmd.scan_run && (age_q < count_q);
	assign ram_re     = cmd.fetch || scan_issue;
	assign ram_raddr  = cmd.fetch ? pos_slot : scan_slot_q;

	dhr_ram #(
		.WIDTH(HANDLE_W),
		.DEPTH(ENTRIES)
	) u_ram (
		.clk  (clk),
		.we   (cmd.store),
		.waddr(scan_slot_q),
		.wdata(cap_handle_q),
		.re   (ram_re),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			oldest_q    <= '0;
			count_q     <= '0;
			cmp_vld_q   <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.store) begin
				if (full) begin
					oldest_q <= slot_inc(oldest_q);
				end else begin
					count_q <= count_q + 1'b1;
				end
			end
			cmp_vld_q <= scan_issue;
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			cap_cmd_q      <= cmd_in;
			cap_handle_q   <= handle;
			cap_position_q <= position;
		end
		if (cmd.scan_init) begin
			age_q       <= '0;
			scan_slot_q <= oldest_q;
		end else if (scan_issue) begin
			age_q       <= age_q + 1'b1;
			scan_slot_q <= slot_inc(scan_slot_q);
		end
		if (cmd.res_set) begin
			res_status_q  <= cmd.res_code;
			res_handle_q  <= cmd.res_take_data ? ram_rdata : '0;
			res_evicted_q <= cmd.store && full;
		end
		if (cmd.out_load) begin
			out_status_q  <= res_status_q;
			out_handle_q  <= res_handle_q;
			out_live_q    <= count_ext[LIVE_W-1:0];
			out_evicted_q <= res_evicted_q;
		end
	end

	assign sts.is_read     = (cap_cmd_q == CMD_READ);
	assign sts.pos_ok      = (pos_ext < count_ext);
	assign sts.zero_handle = (cap_handle_q == '0);
	assign sts.scan_more   = (age_q < count_q);
	assign sts.cmp_valid   = cmp_vld_q;
	assign sts.cmp_hit     = cmp_vld_q && (ram_rdata == cap_handle_q);
	assign sts.out_free    = !out_valid_q || out_ready;

	assign out_valid  = out_valid_q;
	assign status     = out_status_q;
	assign handle_out = out_handle_q;
	assign live_count = out_live_q;
	assign evicted    = out_evicted_q;

	`DHR_ASSERT_NEXT(a_evict_moves_oldest, cmd.store && full,
		(oldest_q != $past(oldest_q)) && (count_q == $past(count_q)))
	`DHR_ASSERT_NEXT(a_store_grows, cmd.store && !full, count_q == $past(count_q) + 1'b1)
	`DHR_ASSERT_IMP(a_compare_follows_read, cmp_vld_q, $past(scan_issue))

endmodule

// ===== test/dedup_history_ring_tb.sv =====
`timescale 1ns / 1ps
// self-checking testbench for the deduplicating handle ring (dedup_history_ring)
// depends on dhr_pkg and the dedup_history_ring rtl, nothing else

module dedup_history_ring_tb;
	import dhr_pkg::*;

	localparam int RING_SLOTS = 512;
	// no beat accepted for this many cycles means the block hung
	localparam int HANG_LIMIT = 20000;
	// sized to outlast a save scan on a full ring
	localparam int TAIL_CYCLES = 600;
	localparam int TOTAL_BEATS = 1170;

	// one result beat as the block should report it
	typedef struct packed {
		dhr_status_t         status;
		logic [HANDLE_W-1:0] handle_out;
		logic [LIVE_W-1:0]   live_count;
		logic                evicted;
	} ring_result_t;

	logic                clk;
	logic                arst_n;
	logic                in_valid;
	logic                in_ready;
	logic                cmd;
	logic [HANDLE_W-1:0] handle;
	logic [POS_W-1:0]    position;
	logic                out_valid;
	logic                out_ready;
	logic [STATUS_W-1:0] status;
	logic [HANDLE_W-1:0] handle_out;
	logic [LIVE_W-1:0]   live_count;
	logic                evicted;

	// shadow copy of the ring kept by the predictor
	logic [HANDLE_W-1:0] ring_mem [RING_SLOTS];
	int                  ring_head;
	int                  ring_fill;
	// handles pushed out of the ring, offered again later to prove they are gone
	logic [HANDLE_W-1:0] dropped_handles [$];

	ring_result_t        results_due [$];
	ring_result_t        want;
	int                  mismatches;
	int                  beats_sent;
	int                  stall_cycles;
	int                  src_idle_pct;
	int                  snk_idle_pct;

	dedup_history_ring #(
		.ENTRIES(RING_SLOTS)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.cmd(cmd),
		.handle(handle),
		.position(position),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.status(status),
		.handle_out(handle_out),
		.live_count(live_count),
		.evicted(evicted)
	);

	initial clk = 1'b0;
	always #2 clk = ~clk;

	// apply one accepted beat to the shadow ring and return what the block must answer
	function automatic ring_result_t ring_apply(logic c, logic [HANDLE_W-1:0] h,
			logic [POS_W-1:0] p);
		ring_result_t r;
		int age;
		bit hit;
		r.status = STAT_ZERO;
		r.handle_out = '0;
		r.evicted = 1'b0;
		hit = 1'b0;
		if (c == CMD_READ) begin
			if (int'(p) < ring_fill) begin
				r.handle_out = ring_mem[(ring_head + int'(p)) % RING_SLOTS];
				r.status = STAT_READ_OK;
			end else begin
				r.status = STAT_BEYOND;
			end
		end else if (h == '0) begin
			// failed capture, nothing changes
			r.status = STAT_ZERO;
		end else begin
			// oldest to newest, first match wins
			for (age = 0; age < ring_fill; age++) begin
				if (ring_mem[(ring_head + age) % RING_SLOTS] == h) begin
					hit = 1'b1;
					break;
				end
			end
			if (hit) begin
				r.status = STAT_DUP;
			end else begin
				ring_mem[(ring_head + ring_fill) % RING_SLOTS] = h;
				ring_fill++;
				// one slot always stays free, so a full ring drops its oldest entry
				if (ring_fill >= RING_SLOTS) begin
					dropped_handles.push_back(ring_mem[ring_head]);
					if (dropped_handles.size() > 64)
						void'(dropped_handles.pop_front());
					ring_head = (ring_head + 1) % RING_SLOTS;
					ring_fill = RING_SLOTS - 1;
					r.evicted = 1'b1;
				end
				r.status = STAT_STORED;
			end
		end
		r.live_count = ring_fill[LIVE_W-1:0];
		return r;
	endfunction

	// drive one beat at the falling edge, hold it until accepted, then predict
	task automatic offer_beat(logic c, logic [HANDLE_W-1:0] h, logic [POS_W-1:0] p);
		@(negedge clk);
		while (src_idle_pct != 0 && $urandom_range(99) < src_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		cmd <= c;
		handle <= h;
		position <= p;
		do @(posedge clk); while (!in_ready);
		results_due.push_back(ring_apply(c, h, p));
		beats_sent++;
	endtask

	// sender holds off until every outstanding result has come back
	task automatic wait_drained();
		@(negedge clk);
		in_valid <= 1'b0;
		while (results_due.size() != 0)
			@(posedge clk);
	endtask

	// reads and a zero save against an empty ring
	task automatic test_empty_ring();
		offer_beat(CMD_READ, 32'h0, 9'd0);
		offer_beat(CMD_READ, 32'hFFFF_FFFF, 9'd511);
		offer_beat(CMD_SAVE, 32'h0, 9'd511);
	endtask

	// a few stores, duplicates at both ends, zero handle, reads at the edges
	task automatic test_basic_saves();
		offer_beat(CMD_SAVE, 32'hFFFF_FFFF, 9'd0);
		offer_beat(CMD_SAVE, 32'h0000_0001, 9'h1FF);
		offer_beat(CMD_SAVE, 32'h8000_0000, 9'd0);
		offer_beat(CMD_SAVE, 32'hFFFF_FFFF, 9'd0);
		offer_beat(CMD_SAVE, 32'h8000_0000, 9'd0);
		offer_beat(CMD_SAVE, 32'h0, 9'd0);
		offer_beat(CMD_READ, 32'h0, 9'd0);
		offer_beat(CMD_READ, 32'hDEAD_BEEF, 9'd2);
		offer_beat(CMD_READ, 32'h0, 9'd3);
		offer_beat(CMD_READ, 32'h0, 9'd511);
	endtask

	// random beats weighted toward fresh stores and lookups of live entries
	task automatic test_mixed_traffic(int count);
		int i;
		int roll;
		int age;
		logic [HANDLE_W-1:0] pick;
		for (i = 0; i < count; i++) begin
			roll = $urandom_range(99);
			pick = $urandom;
			if (roll < 50) begin
				offer_beat(CMD_SAVE, pick, POS_W'($urandom));
			end else if (roll < 62) begin
				// duplicate of the oldest, the newest or any live entry
				if (ring_fill > 0) begin
					case ($urandom_range(2))
						0: age = 0;
						1: age = ring_fill - 1;
						default: age = $urandom_range(ring_fill - 1);
					endcase
					pick = ring_mem[(ring_head + age) % RING_SLOTS];
				end
				offer_beat(CMD_SAVE, pick, POS_W'($urandom));
			end else if (roll < 66) begin
				offer_beat(CMD_SAVE, 32'h0, POS_W'($urandom));
			end else if (roll < 70) begin
				// an evicted handle must be stored again, not flagged as duplicate
				if (dropped_handles.size() != 0)
					pick = dropped_handles[$urandom_range(dropped_handles.size() - 1)];
				offer_beat(CMD_SAVE, pick, POS_W'($urandom));
			end else if (roll < 88) begin
				age = (ring_fill == 0) ? 0 : $urandom_range(ring_fill - 1);
				offer_beat(CMD_READ, pick, POS_W'(age));
			end else if (roll < 95) begin
				offer_beat(CMD_READ, pick, POS_W'($urandom_range(511, ring_fill)));
			end else begin
				offer_beat(CMD_READ, pick, POS_W'($urandom));
			end
		end
	endtask

	// fresh stores with a few reads until every usable slot is live
	task automatic test_fill_ring();
		while (ring_fill < RING_SLOTS - 1) begin
			if ($urandom_range(9) == 0)
				offer_beat(CMD_READ, $urandom, POS_W'($urandom_range(ring_fill)));
			else
				offer_beat(CMD_SAVE, $urandom, POS_W'($urandom));
		end
	endtask

	// edges of a full ring: last position, duplicates at both ends, eviction, re-store
	task automatic test_full_ring();
		offer_beat(CMD_READ, 32'h0, 9'd510);
		offer_beat(CMD_READ, 32'h0, 9'd511);
		offer_beat(CMD_SAVE, ring_mem[ring_head], 9'd0);
		offer_beat(CMD_SAVE, ring_mem[(ring_head + ring_fill - 1) % RING_SLOTS], 9'd0);
		offer_beat(CMD_SAVE, $urandom | 32'h1, 9'd0);
		offer_beat(CMD_SAVE, dropped_handles[$], 9'd0);
		offer_beat(CMD_READ, 32'h0, 9'd0);
	endtask

	// sink side: random back-pressure, new decision every falling edge
	always @(negedge clk) begin
		out_ready <= ($urandom_range(99) >= snk_idle_pct);
	end

	// compare every accepted result beat against the oldest prediction
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (results_due.size() == 0) begin
				$display("%0t: unexpected result beat, expected none, got status %0d handle %h",
					$time, status, handle_out);
				mismatches++;
			end else begin
				want = results_due.pop_front();
				if (status !== want.status) begin
					$display("%0t: status mismatch, expected %0d, got %0d",
						$time, want.status, status);
					mismatches++;
				end
				if (handle_out !== want.handle_out) begin
					$display("%0t: handle_out mismatch, expected %h, got %h",
						$time, want.handle_out, handle_out);
					mismatches++;
				end
				if (live_count !== want.live_count) begin
					$display("%0t: live_count mismatch, expected %0d, got %0d",
						$time, want.live_count, live_count);
					mismatches++;
				end
				if (evicted !== want.evicted) begin
					$display("%0t: evicted mismatch, expected %b, got %b",
						$time, want.evicted, evicted);
					mismatches++;
				end
			end
		end
	end

	// hang detection: any beat on either side restarts the count
	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
			stall_cycles <= 0;
		end else if (stall_cycles >= HANG_LIMIT) begin
			$display("%0t: no beat accepted for %0d cycles", $time, HANG_LIMIT);
			$display("dedup_history_ring test failed");
			$finish;
		end else begin
			stall_cycles <= stall_cycles + 1;
		end
	end

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		cmd = CMD_SAVE;
		handle = '0;
		position = '0;
		out_ready = 1'b0;
		ring_head = 0;
		ring_fill = 0;
		mismatches = 0;
		beats_sent = 0;
		stall_cycles = 0;
		src_idle_pct = 20;
		snk_idle_pct = 20;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_empty_ring();
		test_basic_saves();
		wait_drained();
		test_mixed_traffic(300);
		test_fill_ring();
		wait_drained();
		test_full_ring();
		// long stretch with both sides always ready
		src_idle_pct = 0;
		snk_idle_pct = 0;
		test_mixed_traffic(300);
		wait_drained();
		src_idle_pct = 20;
		snk_idle_pct = 20;
		if (beats_sent < TOTAL_BEATS)
			test_mixed_traffic(TOTAL_BEATS - beats_sent);

		@(negedge clk);
		in_valid <= 1'b0;
		while (results_due.size() != 0)
			@(posedge clk);
		// catch any stray result beat after the last expected one
		repeat (TAIL_CYCLES) @(posedge clk);
		if (mismatches == 0)
			$display("dedup_history_ring test passed");
		else
			$display("dedup_history_ring test failed");
		$finish;
	end

endmodule

// ===== files.f =====
+incdir+hdl
hdl/dhr_pkg.sv
hdl/dhr_ram.sv
hdl/dhr_ctrl.sv
hdl/dhr_dp.sv
hdl/dedup_history_ring.sv
test/dedup_history_ring_tb.sv
